// ===== design/satq_pkg.sv =====
`default_nettype none

package satq_pkg;

  localparam int unsigned IDX_W    = 6;
  localparam int unsigned CFG_W    = 7;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RECT   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_SUM,
    ST_LD_ADD,
    ST_LD_WR,
    ST_Q_RD0,
    ST_Q_RD1,
    ST_Q_RD2,
    ST_Q_RD3,
    ST_Q_FIN,
    ST_PUT
  } state_e;

  typedef enum logic [2:0] {
    ALU_HOLD,
    ALU_PASS,
    ALU_ADD,
    ALU_SUB,
    ALU_CLR
  } alu_op_e;

  typedef struct packed {
    alu_op_e op;
    logic    a_from_acc;
  } alu_ctl_t;

endpackage

`default_nettype wire

// ===== design/satq_mem.sv =====
`default_nettype none

module satq_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/satq_alu.sv =====
`default_nettype none

module satq_alu
  import satq_pkg::*;
#(
  parameter int unsigned DW = 32
) (
  input  wire logic          clk_i,
  input  wire alu_ctl_t      ctl_i,
  input  wire logic [DW-1:0] a_i,
  input  wire logic [DW-1:0] b_i,
  output logic      [DW-1:0] acc_o
);

  logic [DW-1:0] acc_q;
  logic [DW-1:0] acc_d;
  logic [DW-1:0] a_sel;

  assign a_sel = ctl_i.a_from_acc ? acc_q : a_i;

  always_comb begin
    case (ctl_i.op)
      ALU_HOLD: acc_d = acc_q;
      ALU_PASS: acc_d = a_sel;
      ALU_ADD:  acc_d = a_sel + b_i;
      ALU_SUB:  acc_d = a_sel - b_i;
      ALU_CLR:  acc_d = '0;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ===== design/summed_area_table_query.sv =====
// Load item, in order: accept, add row sum, add entry above, write; no new item is taken
//   until the write is done, as the steps share the single adder and the single table port.
// Query item, in order: accept, four table reads folded into one accumulator, final add,
//   result register and output; an invalid or early query goes from acceptance to output.
// Reset clears control state and sets both size registers to 64; the table itself is not
//   cleared and its contents are only used where a completed load has written them.
`default_nettype none

module summed_area_table_query
  import satq_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // element_value[31:0], top_row[37:32], left_col[43:38], bottom_row[49:44], right_col[55:50]
  input  wire logic [55:0]          s_axis_tdata,
  // func[0]
  input  wire logic [0:0]           s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // rect_sum[31:0]
  output logic [31:0]               m_axis_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]       m_axis_tuser
);

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);
  localparam int unsigned EW    = (DATA_WIDTH > ELEM_W) ? DATA_WIDTH : ELEM_W;

  function automatic logic [AW-1:0] cell_addr(input int unsigned r, input int unsigned c);
    return AW'(r * MAX_COLS + c);
  endfunction

  state_e state_q, state_d;

  logic [CFG_W-1:0]      rows_q, cols_q;
  logic [CFG_W-1:0]      nr, nc;
  logic [RW-1:0]         row_q;
  logic [CW-1:0]         col_q;
  logic [DATA_WIDTH-1:0] run_q;
  logic                  complete_q;
  logic [DATA_WIDTH-1:0] elem_q;
  logic [IDX_W-1:0]      t_q, l_q, b_q, r_q;
  logic [IDX_W-1:0]      tm1, lm1;
  logic [STATUS_W-1:0]   status_q;
  logic                  m_valid_q;
  logic [31:0]           m_data_q;
  logic [STATUS_W-1:0]   m_user_q;

  logic                  in_fire, put_fire;
  logic                  is_load;
  logic                  ld_restart;
  logic                  q_bad_rect;
  logic [IDX_W-1:0]      in_t, in_l, in_b, in_r;
  logic signed [EW-1:0]  elem_ext;
  logic [EW-1:0]         acc_ext;

  alu_ctl_t              alu_ctl;
  logic [DATA_WIDTH-1:0] alu_a, alu_b, acc;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign nr = (rows_q == '0) ? CFG_W'(1) :
              ((32'(rows_q) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_q);
  assign nc = (cols_q == '0) ? CFG_W'(1) :
              ((32'(cols_q) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_q);

  assign in_t = s_axis_tdata[37:32];
  assign in_l = s_axis_tdata[43:38];
  assign in_b = s_axis_tdata[49:44];
  assign in_r = s_axis_tdata[55:50];
  assign elem_ext = EW'($signed(s_axis_tdata[31:0]));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_load       = (s_axis_tuser[0] == FUNC_LOAD);
  assign put_fire      = (state_q == ST_PUT) && (!m_valid_q || m_axis_tready);

  assign ld_restart = complete_q || (32'(row_q) >= 32'(nr)) || (32'(col_q) >= 32'(nc));
  assign q_bad_rect = (in_t > in_b) || (in_l > in_r) ||
                      (32'(in_b) >= 32'(nr)) || (32'(in_r) >= 32'(nc));

  assign tm1 = (t_q == '0) ? '0 : t_q - IDX_W'(1);
  assign lm1 = (l_q == '0) ? '0 : l_q - IDX_W'(1);

  assign acc_ext = EW'(acc);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_load) begin
            state_d = ST_LD_SUM;
          end else if (!complete_q || q_bad_rect) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_Q_RD0;
          end
        end
      end
      ST_LD_SUM: state_d = ST_LD_ADD;
      ST_LD_ADD: state_d = ST_LD_WR;
      ST_LD_WR:  state_d = ST_IDLE;
      ST_Q_RD0:  state_d = ST_Q_RD1;
      ST_Q_RD1:  state_d = ST_Q_RD2;
      ST_Q_RD2:  state_d = ST_Q_RD3;
      ST_Q_RD3:  state_d = ST_Q_FIN;
      ST_Q_FIN:  state_d = ST_PUT;
      ST_PUT: begin
        if (put_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_ctl  = '{op: ALU_HOLD, a_from_acc: 1'b0};
    alu_a    = '0;
    alu_b    = '0;
    mem_we   = 1'b0;
    mem_addr = cell_addr(32'(row_q), 32'(col_q));
    case (state_q)
      ST_IDLE: begin
        if (in_fire && !is_load) begin
          alu_ctl.op = ALU_CLR;
        end
      end
      ST_LD_SUM: begin
        alu_ctl.op = ALU_ADD;
        alu_a      = (col_q == '0) ? '0 : run_q;
        alu_b      = elem_q;
        mem_addr   = cell_addr((row_q == '0) ? 0 : 32'(row_q) - 1, 32'(col_q));
      end
      ST_LD_ADD: begin
        alu_ctl = '{op: ALU_ADD, a_from_acc: 1'b1};
        alu_b   = (row_q == '0) ? '0 : mem_rdata;
      end
      ST_LD_WR: begin
        mem_we = 1'b1;
      end
      ST_Q_RD0: begin
        mem_addr = cell_addr(32'(b_q), 32'(r_q));
      end
      ST_Q_RD1: begin
        alu_ctl.op = ALU_PASS;
        alu_a      = mem_rdata;
        mem_addr   = cell_addr(32'(tm1), 32'(r_q));
      end
      ST_Q_RD2: begin
        alu_ctl  = '{op: ALU_SUB, a_from_acc: 1'b1};
        alu_b    = (t_q == '0) ? '0 : mem_rdata;
        mem_addr = cell_addr(32'(b_q), 32'(lm1));
      end
      ST_Q_RD3: begin
        alu_ctl  = '{op: ALU_SUB, a_from_acc: 1'b1};
        alu_b    = (l_q == '0) ? '0 : mem_rdata;
        mem_addr = cell_addr(32'(tm1), 32'(lm1));
      end
      ST_Q_FIN: begin
        alu_ctl = '{op: ALU_ADD, a_from_acc: 1'b1};
        alu_b   = ((t_q == '0) || (l_q == '0)) ? '0 : mem_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rows_q     <= CFG_W'(64);
      cols_q     <= CFG_W'(64);
      row_q      <= '0;
      col_q      <= '0;
      run_q      <= '0;
      complete_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROWS_IN_USE: rows_q <= cfg_data_i;
          CFG_COLS_IN_USE: cols_q <= cfg_data_i;
          default: begin
          end
        endcase
        row_q      <= '0;
        col_q      <= '0;
        run_q      <= '0;
        complete_q <= 1'b0;
      end else if (in_fire && is_load && ld_restart) begin
        row_q      <= '0;
        col_q      <= '0;
        run_q      <= '0;
        complete_q <= 1'b0;
      end else if (state_q == ST_LD_ADD) begin
        run_q <= acc;
      end else if (state_q == ST_LD_WR) begin
        if (32'(col_q) + 1 >= 32'(nc)) begin
          col_q <= '0;
          run_q <= '0;
          if (32'(row_q) + 1 >= 32'(nr)) begin
            row_q      <= '0;
            complete_q <= 1'b1;
          end else begin
            row_q <= row_q + RW'(1);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (put_fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      elem_q <= elem_ext[DATA_WIDTH-1:0];
      t_q    <= in_t;
      l_q    <= in_l;
      b_q    <= in_b;
      r_q    <= in_r;
      if (!complete_q) begin
        status_q <= STATUS_NOT_LOADED;
      end else if (q_bad_rect) begin
        status_q <= STATUS_BAD_RECT;
      end else begin
        status_q <= STATUS_OK;
      end
    end
    if (put_fire) begin
      m_data_q <= acc_ext[ELEM_W-1:0];
      m_user_q <= status_q;
    end
  end

  satq_alu #(
    .DW (DATA_WIDTH)
  ) u_alu (
    .clk_i (clk_i),
    .ctl_i (alu_ctl),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .acc_o (acc)
  );

  satq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (acc),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_out_from_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_PUT))
    else $error("result appeared outside the output step");

  a_early_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_load && !complete_q) |=>
      (state_q == ST_PUT) && (status_q == STATUS_NOT_LOADED))
    else $error("query before table complete not flagged");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !complete_q && (row_q == '0) && (col_q == '0))
    else $error("register write did not restart loading");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LD_WR && !cfg_we_i) |=>
      complete_q || (row_q != $past(row_q)) || (col_q != $past(col_q)))
    else $error("load position did not advance after table write");

endmodule

`default_nettype wire
